/* rtl/htrc_pkg.sv */
// shared constants and types for the homography track residual cost unit
package htrc_pkg;

  localparam int MAX_FRAMES_DEFAULT = 1024;
  localparam int COEF_COUNT         = 9;
  localparam int FRAME_W            = 10;
  localparam int COEF_IDX_W         = 4;
  localparam int COEF_W             = 32;
  localparam int COORD_W            = 20;
  localparam int ERR_W              = 48;
  localparam int SUM_W              = 56;
  localparam int S_TDATA_W          = 128;
  localparam int M_TDATA_W          = 152;
  localparam int ACC_W              = 56;

  // shared multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // shared divider widths
  localparam int DIV_DEND_W = 64;
  localparam int DIV_DSOR_W = 57;
  localparam int DIV_CNT_W  = 7;

  localparam logic [DIV_CNT_W-1:0] DIV_Q8_STEPS   = 7'd64;
  localparam logic [DIV_CNT_W-1:0] DIV_COST_STEPS = 7'd48;

  localparam logic [ERR_W-1:0] THR_RESET = 48'd262144;
  localparam logic [ERR_W-1:0] ERR_SAT   = {ERR_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_SAT   = {SUM_W{1'b1}};
  localparam logic [MUL_B_W-1:0] COORD_ONE = 26'd256;

  typedef enum logic {
    OP_COEF = 1'b0,
    OP_PAIR = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_DSOR_W-1:0] rem0;
    logic [DIV_DEND_W-1:0] dividend;
    logic [DIV_DSOR_W-1:0] divisor;
    logic [DIV_CNT_W-1:0]  iters;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIV_DEND_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/homography_track_residual_cost_unit.sv */
// top level: homography store, projection residual and truncated quadratic track cost
//
// usage
//   s_axis carries one beat per item: tuser[0] selects a coefficient write (0) or a
//   point pair (1), tuser[1] marks batch end, tlast marks the last pair of a track.
//   a coefficient write goes straight into the homography ram in the accept cycle.
//   a point pair reads the nine coefficients of its frame, runs them through one
//   shared multiplier, then, for a nonzero denominator, two 64-step divides on a
//   shared one-bit-per-cycle divider, then, if the difference fits, two squares.
//   a pair that closes a track adds four partial products and a 48-step divide
//   (none when tau2 is zero or below the track maximum) and gives one beat on m_axis
//   (tlast = batch end). the divider produces one quotient bit per cycle.
//   the block takes one pair at a time; s_axis_tready is high only while idle.
//   a finished result sits in the output register, so the next item is accepted
//   while it waits; a second result waits inside the block until the first is taken.
//   cfg_wr_en writes tau2 at once; write it only while the block is idle.
//   reset (synchronous, active high) clears track maximum and running total, loads
//   tau2 = 262144; the coefficient ram is not cleared and must be written before use.
module homography_track_residual_cost_unit #(
  parameter int MAX_FRAMES = htrc_pkg::MAX_FRAMES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // frame_index, coef_index, coef_value, x_from, y_from, x_to, y_to, zero pad
  input  logic [htrc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tlast,
  // opcode, batch_end
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // track_residual_sq, track_cost, total_cost
  output logic [htrc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_wr_en,
  input  logic [htrc_pkg::ERR_W-1:0]         cfg_wr_data
);

  localparam int DEPTH = MAX_FRAMES * htrc_pkg::COEF_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [3:0] LAST_COEF = 4'(htrc_pkg::COEF_COUNT - 1);
  localparam logic [3:0] COEF_CNT  = 4'(htrc_pkg::COEF_COUNT);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MAC    = 12'b0000_0000_0010,
    S_CHK    = 12'b0000_0000_0100,
    S_DIVX   = 12'b0000_0000_1000,
    S_DIVY   = 12'b0000_0001_0000,
    S_DIFF   = 12'b0000_0010_0000,
    S_SQ     = 12'b0000_0100_0000,
    S_MAX    = 12'b0000_1000_0000,
    S_COST   = 12'b0001_0000_0000,
    S_CSTART = 12'b0010_0000_0000,
    S_CDIV   = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_t;

  function automatic logic [htrc_pkg::ACC_W-1:0] mag_acc(
    input logic signed [htrc_pkg::ACC_W-1:0] v
  );
    mag_acc = v[htrc_pkg::ACC_W-1] ? htrc_pkg::ACC_W'(-v) : htrc_pkg::ACC_W'(v);
  endfunction

  // input unpack
  logic                             in_opcode;
  logic                             in_batch_end;
  logic [htrc_pkg::FRAME_W-1:0]     in_frame;
  logic [htrc_pkg::COEF_IDX_W-1:0]  in_cidx;
  logic [htrc_pkg::COEF_W-1:0]      in_cval;
  logic [htrc_pkg::COORD_W-1:0]     in_x_from, in_y_from, in_x_to, in_y_to;

  assign in_opcode    = s_axis_tuser[0];
  assign in_batch_end = s_axis_tuser[1];
  assign in_frame     = s_axis_tdata[9:0];
  assign in_cidx      = s_axis_tdata[13:10];
  assign in_cval      = s_axis_tdata[45:14];
  assign in_x_from    = s_axis_tdata[65:46];
  assign in_y_from    = s_axis_tdata[85:66];
  assign in_x_to      = s_axis_tdata[105:86];
  assign in_y_to      = s_axis_tdata[125:106];

  state_t state;
  logic   s_accept;
  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // frame index modulo MAX_FRAMES, conditional subtract per bit
  logic [htrc_pkg::FRAME_W-1:0] frame_red;
  logic [26:0]                  lim;
  always_comb begin
    frame_red = in_frame;
    lim       = '0;
    for (int i = htrc_pkg::FRAME_W - 1; i >= 0; i--) begin
      lim = 27'(MAX_FRAMES) << i;
      if ({17'd0, frame_red} >= lim) begin
        frame_red = frame_red - lim[htrc_pkg::FRAME_W-1:0];
      end
    end
  end

  logic [AW-1:0] frame_base;
  assign frame_base = AW'(frame_red) * AW'(htrc_pkg::COEF_COUNT);

  // registers
  logic [AW-1:0]                   base;
  logic [htrc_pkg::COORD_W-1:0]    x_from, y_from, x_to, y_to;
  logic                            tend, bend;
  logic [3:0]                      cnt;
  logic                            rd_vld, mul_vld;
  logic [3:0]                      rd_k, mul_k;
  logic signed [htrc_pkg::ACC_W-1:0] acc0, acc1, acc2;
  logic                            negx, negy;
  logic [htrc_pkg::DIV_DEND_W-1:0] qx, qy;
  logic [23:0]                     dxm, dym;
  logic [htrc_pkg::ERR_W:0]        e_acc;
  logic [htrc_pkg::ERR_W-1:0]      err;
  logic [htrc_pkg::ERR_W-1:0]      track_max;
  logic [htrc_pkg::ERR_W-1:0]      thr;
  logic [97:0]                     prod;
  logic [htrc_pkg::ERR_W-1:0]      cost;
  logic [htrc_pkg::SUM_W-1:0]      cost_sum;
  logic                            out_load;

  // coefficient ram
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [htrc_pkg::COEF_W-1:0] ram_rdata;

  assign ram_we    = s_accept && (in_opcode == htrc_pkg::OP_COEF) && (in_cidx < COEF_CNT);
  assign ram_waddr = frame_base + AW'(in_cidx);
  assign ram_re    = (state == S_MAC) && (cnt < COEF_CNT);
  assign ram_raddr = base + AW'(cnt);

  htrc_ram #(
    .WIDTH (htrc_pkg::COEF_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_cval),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // cost operands: a = r, b = 2*tau2 - r
  logic [48:0] cost_b;
  logic        cost_mult;
  assign cost_b    = {thr, 1'b0} - 49'(track_max);
  assign cost_mult = (cnt != 4'd0) || !((thr < track_max) || (thr == '0));

  // shared multiplier operand select
  logic signed [htrc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [htrc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [htrc_pkg::MUL_P_W-1:0] mul_p;
  logic                                mul_issue;
  logic [3:0]                          issue_k;

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_issue = 1'b0;
    issue_k   = cnt;
    unique case (state)
      S_MAC: begin
        mul_issue = rd_vld;
        issue_k   = rd_k;
        mul_a     = $signed(ram_rdata);
        case (rd_k) inside
          4'd0, 4'd3, 4'd6: mul_b = htrc_pkg::MUL_B_W'(x_from);
          4'd1, 4'd4, 4'd7: mul_b = htrc_pkg::MUL_B_W'(y_from);
          default:          mul_b = htrc_pkg::COORD_ONE;
        endcase
      end
      S_SQ: begin
        mul_issue = cnt < 4'd2;
        mul_a     = (cnt == 4'd0) ? htrc_pkg::MUL_A_W'(dxm) : htrc_pkg::MUL_A_W'(dym);
        mul_b     = (cnt == 4'd0) ? htrc_pkg::MUL_B_W'(dxm) : htrc_pkg::MUL_B_W'(dym);
      end
      S_COST: begin
        mul_issue = cost_mult && (cnt < 4'd4);
        case (cnt)
          4'd0: begin
            mul_a = htrc_pkg::MUL_A_W'(track_max[23:0]);
            mul_b = htrc_pkg::MUL_B_W'(cost_b[24:0]);
          end
          4'd1: begin
            mul_a = htrc_pkg::MUL_A_W'(track_max[23:0]);
            mul_b = htrc_pkg::MUL_B_W'(cost_b[48:25]);
          end
          4'd2: begin
            mul_a = htrc_pkg::MUL_A_W'(track_max[47:24]);
            mul_b = htrc_pkg::MUL_B_W'(cost_b[24:0]);
          end
          default: begin
            mul_a = htrc_pkg::MUL_A_W'(track_max[47:24]);
            mul_b = htrc_pkg::MUL_B_W'(cost_b[48:25]);
          end
        endcase
      end
      default: ;
    endcase
  end

  htrc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // partial product placed at its weight
  logic [97:0] part_shifted;
  always_comb begin
    case (mul_k)
      4'd0:    part_shifted = 98'($unsigned(mul_p));
      4'd1:    part_shifted = 98'($unsigned(mul_p)) << 25;
      4'd2:    part_shifted = 98'($unsigned(mul_p)) << 24;
      default: part_shifted = 98'($unsigned(mul_p)) << 49;
    endcase
  end

  // shared divider requests
  htrc_pkg::div_req_t div_req;
  htrc_pkg::div_rsp_t div_rsp;
  logic [htrc_pkg::ACC_W-1:0] mag0, mag1, mag2;
  assign mag0 = mag_acc(acc0);
  assign mag1 = mag_acc(acc1);
  assign mag2 = mag_acc(acc2);

  always_comb begin
    div_req = '0;
    unique case (state)
      S_CHK: begin
        div_req.start    = (acc2 != '0);
        div_req.dividend = (64'(mag0) << 9) + 64'(mag2);
        div_req.divisor  = htrc_pkg::DIV_DSOR_W'(mag2) << 1;
        div_req.iters    = htrc_pkg::DIV_Q8_STEPS;
      end
      S_DIVX: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = (64'(mag1) << 9) + 64'(mag2);
        div_req.divisor  = htrc_pkg::DIV_DSOR_W'(mag2) << 1;
        div_req.iters    = htrc_pkg::DIV_Q8_STEPS;
      end
      S_CSTART: begin
        div_req.start    = 1'b1;
        div_req.rem0     = htrc_pkg::DIV_DSOR_W'(prod[97:48]);
        div_req.dividend = {prod[47:0], 16'd0};
        div_req.divisor  = htrc_pkg::DIV_DSOR_W'({thr, 2'b00});
        div_req.iters    = htrc_pkg::DIV_COST_STEPS;
      end
      default: ;
    endcase
  end

  htrc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // target minus projected point, magnitude and overflow
  logic signed [65:0] qxs, qys, dxs, dys;
  logic [65:0]        dxa, dya;
  logic               diff_sat;
  always_comb begin
    qxs      = negx ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
    qys      = negy ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
    dxs      = $signed(66'(x_to)) - qxs;
    dys      = $signed(66'(y_to)) - qys;
    dxa      = dxs[65] ? 66'(-dxs) : 66'(dxs);
    dya      = dys[65] ? 66'(-dys) : 66'(dys);
    diff_sat = (dxa[65:24] != '0) || (dya[65:24] != '0);
  end

  logic [htrc_pkg::ERR_W:0]   esum;
  logic [htrc_pkg::SUM_W:0]   sum_wide;
  logic [htrc_pkg::SUM_W-1:0] sum_sat;
  assign esum     = e_acc + (htrc_pkg::ERR_W + 1)'($unsigned(mul_p));
  assign sum_wide = (htrc_pkg::SUM_W + 1)'(cost_sum) + (htrc_pkg::SUM_W + 1)'(cost);
  assign sum_sat  = sum_wide[htrc_pkg::SUM_W] ? htrc_pkg::SUM_SAT
                                              : sum_wide[htrc_pkg::SUM_W-1:0];
  assign out_load = (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      rd_vld        <= 1'b0;
      mul_vld       <= 1'b0;
      track_max     <= '0;
      cost_sum      <= '0;
      thr           <= htrc_pkg::THR_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_vld  <= ram_re;
      rd_k    <= cnt;
      mul_vld <= mul_issue;
      mul_k   <= issue_k;
      if (ram_re || (mul_issue && state != S_MAC)) begin
        cnt <= cnt + 4'd1;
      end
      if (cfg_wr_en) begin
        thr <= cfg_wr_data;
      end
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_accept && in_opcode == htrc_pkg::OP_PAIR) begin
            base   <= frame_base;
            x_from <= in_x_from;
            y_from <= in_y_from;
            x_to   <= in_x_to;
            y_to   <= in_y_to;
            tend   <= s_axis_tlast;
            bend   <= in_batch_end;
            acc0   <= '0;
            acc1   <= '0;
            acc2   <= '0;
            cnt    <= '0;
            state  <= S_MAC;
          end
        end
        S_MAC: begin
          if (mul_vld) begin
            case (mul_k) inside
              4'd0, 4'd1, 4'd2: acc0 <= acc0 + htrc_pkg::ACC_W'(mul_p);
              4'd3, 4'd4, 4'd5: acc1 <= acc1 + htrc_pkg::ACC_W'(mul_p);
              default:          acc2 <= acc2 + htrc_pkg::ACC_W'(mul_p);
            endcase
            if (mul_k == LAST_COEF) begin
              state <= S_CHK;
            end
          end
        end
        S_CHK: begin
          negx <= acc0[htrc_pkg::ACC_W-1] ^ acc2[htrc_pkg::ACC_W-1];
          negy <= acc1[htrc_pkg::ACC_W-1] ^ acc2[htrc_pkg::ACC_W-1];
          if (acc2 == '0) begin
            err   <= htrc_pkg::ERR_SAT;
            state <= S_MAX;
          end else begin
            state <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            qx    <= div_rsp.quot;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_rsp.done) begin
            qy    <= div_rsp.quot;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          dxm <= dxa[23:0];
          dym <= dya[23:0];
          if (diff_sat) begin
            err   <= htrc_pkg::ERR_SAT;
            state <= S_MAX;
          end else begin
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_vld) begin
            if (mul_k == 4'd0) begin
              e_acc <= (htrc_pkg::ERR_W + 1)'($unsigned(mul_p));
            end else begin
              err   <= (esum > (htrc_pkg::ERR_W + 1)'(htrc_pkg::ERR_SAT)) ?
                       htrc_pkg::ERR_SAT : esum[htrc_pkg::ERR_W-1:0];
              state <= S_MAX;
            end
          end
        end
        S_MAX: begin
          if (err > track_max) begin
            track_max <= err;
          end
          if (tend) begin
            cnt   <= '0;
            state <= S_COST;
          end else begin
            state <= S_IDLE;
          end
        end
        S_COST: begin
          if (cnt == 4'd0 && thr < track_max) begin
            cost  <= thr >> 2;
            state <= S_EMIT;
          end else if (cnt == 4'd0 && thr == '0) begin
            cost  <= '0;
            state <= S_EMIT;
          end else if (mul_vld) begin
            prod <= ((mul_k == 4'd0) ? 98'd0 : prod) + part_shifted;
            if (mul_k == 4'd3) begin
              state <= S_CSTART;
            end
          end
        end
        S_CSTART: begin
          state <= S_CDIV;
        end
        S_CDIV: begin
          if (div_rsp.done) begin
            cost  <= div_rsp.quot[htrc_pkg::ERR_W-1:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            m_axis_tdata  <= {sum_sat, cost, track_max};
            m_axis_tlast  <= bend;
            m_axis_tvalid <= 1'b1;
            track_max     <= '0;
            cost_sum      <= bend ? '0 : sum_sat;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ram is only written while no pair is being read
  a_ram_wr_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_IDLE)
    else $error("coefficient write outside idle");

  // divider is never restarted while busy
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // nothing left in flight when a new item can be accepted
  a_ready_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_rsp.busy && !mul_vld && !rd_vld)
    else $error("work in flight while ready");

  // a loaded result shows up on the output
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid)
    else $error("loaded result not valid");

endmodule

/* rtl/htrc_ram.sv */
// generic single-write single-read ram with registered read data
module htrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/htrc_mul.sv */
// shared signed multiplier with registered product
module htrc_mul (
  input  logic                                clk,
  input  logic signed [htrc_pkg::MUL_A_W-1:0] a,
  input  logic signed [htrc_pkg::MUL_B_W-1:0] b,
  output logic signed [htrc_pkg::MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* rtl/htrc_div.sv */
// shared restoring divider, one quotient bit per cycle
module htrc_div (
  input  logic               clk,
  input  logic               rst,
  input  htrc_pkg::div_req_t req,
  output htrc_pkg::div_rsp_t rsp
);

  logic [htrc_pkg::DIV_DSOR_W-1:0] rem;
  logic [htrc_pkg::DIV_DSOR_W-1:0] divisor;
  logic [htrc_pkg::DIV_DEND_W-1:0] dend;
  logic [htrc_pkg::DIV_DEND_W-1:0] quot;
  logic [htrc_pkg::DIV_CNT_W-1:0]  cnt;
  logic                            busy;
  logic                            done;
  logic [htrc_pkg::DIV_DSOR_W:0]   trial;
  logic                            ge;

  assign trial = {rem, dend[htrc_pkg::DIV_DEND_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem0;
      dend    <= req.dividend;
      divisor <= req.divisor;
      cnt     <= req.iters;
      quot    <= '0;
    end else if (busy) begin
      rem  <= ge ? htrc_pkg::DIV_DSOR_W'(trial - {1'b0, divisor})
                 : trial[htrc_pkg::DIV_DSOR_W-1:0];
      dend <= {dend[htrc_pkg::DIV_DEND_W-2:0], 1'b0};
      quot <= {quot[htrc_pkg::DIV_DEND_W-2:0], ge};
      cnt  <= cnt - 7'd1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule
